[rtl/hbs_pkg.sv]
// Heartbeat supervisor package: field widths, event and action codes,
// register map, reset values and the command/status types shared by the modules.
// No dependencies.
package hbs_pkg;

   localparam int AGENTS_DEFAULT = 8;
   localparam int MASK_W         = 8;
   localparam int TMO_W          = 8;
   localparam int CNT_W          = 16;
   localparam int MODE_W         = 2;
   localparam int AGENT_W        = 3;
   localparam int ACTION_W       = 2;
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_INDEX_W    = 3;

   localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ANSWER   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FINISHED = 2'd3;

   localparam logic [ACTION_W-1:0] SHUT_NONE     = 2'd0;
   localparam logic [ACTION_W-1:0] SHUT_REBOOT   = 2'd1;

   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE_MASK  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ALIVE_TMO    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TERM_GUARD   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TERM_TMO     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_KEEP_PERIOD  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ALIVE_PERIOD = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_TERM_PERIOD  = 3'd6;

   localparam logic [MASK_W-1:0] RST_ENABLE_MASK  = 8'd255;
   localparam logic [TMO_W-1:0]  RST_ALIVE_TMO    = 8'd5;
   localparam logic [CNT_W-1:0]  RST_TERM_GUARD   = 16'd300;
   localparam logic [CNT_W-1:0]  RST_TERM_TMO     = 16'd600;
   localparam logic [CNT_W-1:0]  RST_KEEP_PERIOD  = 16'd10;
   localparam logic [CNT_W-1:0]  RST_ALIVE_PERIOD = 16'd10;
   localparam logic [CNT_W-1:0]  RST_TERM_PERIOD  = 16'd10;

   typedef struct packed {
      logic [MASK_W-1:0] agent_enable_mask;
      logic [TMO_W-1:0]  alive_timeout;
      logic [CNT_W-1:0]  term_guard_level;
      logic [CNT_W-1:0]  term_timeout;
      logic [CNT_W-1:0]  keepalive_period;
      logic [CNT_W-1:0]  alive_check_period;
      logic [CNT_W-1:0]  term_check_period;
   } hbs_cfg_type;

   typedef struct packed {
      logic load;
      logic apply_event;
      logic prescale;
      logic step;
      logic publish;
   } hbs_cmd_type;

   typedef struct packed {
      logic is_tick;
   } hbs_sts_type;

endpackage

[rtl/hbs_if.sv]
// Heartbeat supervisor channel interfaces: event items in, result items out.
// Depends on hbs_pkg.
interface hbs_req_if
   import hbs_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [AGENT_W-1:0]  agent;
   logic                shutdown_kind;
   logic [MASK_W-1:0]   send_accept;

   modport source (output valid, mode, agent, shutdown_kind, send_accept, input ready);
   modport sink   (input valid, mode, agent, shutdown_kind, send_accept, output ready);
endinterface

interface hbs_rsp_if
   import hbs_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                kick;
   logic [MASK_W-1:0]   request_sent;
   logic [MASK_W-1:0]   restart;
   logic [ACTION_W-1:0] shut_action;

   modport source (output valid, kick, request_sent, restart, shut_action, input ready);
   modport sink   (input valid, kick, request_sent, restart, shut_action, output ready);
endinterface

[rtl/hbs_ctrl.sv]
// Heartbeat supervisor controller: sequences decode, prescale, agent scan and
// result hand-off, and owns the result valid flag. Depends on hbs_pkg.
module hbs_ctrl
   import hbs_pkg::*;
#(
   parameter int SLOTS = AGENTS_DEFAULT,
   parameter int IDX_W = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  hbs_sts_type      sts,
   output hbs_cmd_type      cmd,
   output logic [IDX_W-1:0] idx
);

   typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_SCAN, ST_FINISH} state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             out_valid_ff;
   logic             out_free;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign idx       = idx_ff;

   always_comb begin
      cmd             = '0;
      cmd.load        = (state_ff == ST_IDLE) && req_valid;
      cmd.apply_event = (state_ff == ST_DECODE) && !sts.is_tick;
      cmd.prescale    = (state_ff == ST_DECODE) && sts.is_tick;
      cmd.step        = (state_ff == ST_SCAN);
      cmd.publish     = (state_ff == ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.publish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               idx_ff   <= '0;
               state_ff <= sts.is_tick ? ST_SCAN : ST_FINISH;
            end
            ST_SCAN: begin
               if (idx_ff == IDX_W'(SLOTS - 1)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[rtl/hbs_dp.sv]
// Heartbeat supervisor datapath: prescalers, shutdown countdown, per-agent
// miss counters and flags, result and output registers. Depends on hbs_pkg.
module hbs_dp
   import hbs_pkg::*;
#(
   parameter int SLOTS = AGENTS_DEFAULT,
   parameter int IDX_W = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  hbs_cfg_type         cfg,
   input  hbs_cmd_type         cmd,
   input  logic [IDX_W-1:0]    idx,
   output hbs_sts_type         sts,
   input  logic [MODE_W-1:0]   in_mode,
   input  logic [AGENT_W-1:0]  in_agent,
   input  logic                in_kind,
   input  logic [MASK_W-1:0]   in_accept,
   output logic                out_kick,
   output logic [MASK_W-1:0]   out_sent,
   output logic [MASK_W-1:0]   out_restart,
   output logic [ACTION_W-1:0] out_action
);

   localparam logic [MASK_W-1:0] SLOT_MASK = MASK_W'((1 << SLOTS) - 1);

   // item
   logic [MODE_W-1:0]   mode_ff,   mode_in;
   logic [AGENT_W-1:0]  agent_ff,  agent_in;
   logic                kind_ff,   kind_in;
   logic [MASK_W-1:0]   accept_ff, accept_in;
   // state
   logic [CNT_W-1:0]    kdiv_ff, kdiv_in;
   logic [CNT_W-1:0]    adiv_ff, adiv_in;
   logic [CNT_W-1:0]    tdiv_ff, tdiv_in;
   logic [TMO_W-1:0]    miss_ff [SLOTS];
   logic [TMO_W-1:0]    miss_in [SLOTS];
   logic [MASK_W-1:0]   pending_ff, pending_in;
   logic [MASK_W-1:0]   answered_ff, answered_in;
   logic [ACTION_W-1:0] shut_ff, shut_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                finished_ff, finished_in;
   logic                check_ff, check_in;
   // result under construction and output register
   logic                kick_ff, kick_in;
   logic [MASK_W-1:0]   sent_ff, sent_in;
   logic [MASK_W-1:0]   restart_ff, restart_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic                okick_ff, okick_in;
   logic [MASK_W-1:0]   osent_ff, osent_in;
   logic [MASK_W-1:0]   orestart_ff, orestart_in;
   logic [ACTION_W-1:0] oaction_ff, oaction_in;

   function automatic logic [CNT_W:0] prescale(input logic [CNT_W-1:0] div,
                                                input logic [CNT_W-1:0] period);
      logic [CNT_W-1:0] dec;
      dec = (div != '0) ? div - 1'b1 : div;
      return (dec == '0) ? {1'b1, period} : {1'b0, dec};
   endfunction

   assign sts.is_tick = (mode_ff == MODE_TICK);
   assign out_kick    = okick_ff;
   assign out_sent    = osent_ff;
   assign out_restart = orestart_ff;
   assign out_action  = oaction_ff;

   always_comb begin
      logic [CNT_W:0]    kp, ap, tp;
      logic [CNT_W-1:0]  cnt;
      logic [TMO_W-1:0]  m;
      logic              pend;
      logic [IDX_W-1:0]  aidx;

      mode_in     = mode_ff;
      agent_in    = agent_ff;
      kind_in     = kind_ff;
      accept_in   = accept_ff;
      kdiv_in     = kdiv_ff;
      adiv_in     = adiv_ff;
      tdiv_in     = tdiv_ff;
      miss_in     = miss_ff;
      pending_in  = pending_ff;
      answered_in = answered_ff;
      shut_in     = shut_ff;
      count_in    = count_ff;
      finished_in = finished_ff;
      check_in    = check_ff;
      kick_in     = kick_ff;
      sent_in     = sent_ff;
      restart_in  = restart_ff;
      action_in   = action_ff;
      okick_in    = okick_ff;
      osent_in    = osent_ff;
      orestart_in = orestart_ff;
      oaction_in  = oaction_ff;
      kp          = '0;
      ap          = '0;
      tp          = '0;
      cnt         = count_ff;
      m           = miss_ff[idx];
      pend        = pending_ff[idx];
      aidx        = agent_ff[IDX_W-1:0];

      if (cmd.load) begin
         mode_in   = in_mode;
         agent_in  = in_agent;
         kind_in   = in_kind;
         accept_in = in_accept;
      end

      if (cmd.apply_event) begin
         kick_in    = 1'b0;
         sent_in    = '0;
         restart_in = '0;
         action_in  = SHUT_NONE;
         check_in   = 1'b0;
         case (mode_ff)
            MODE_ANSWER: begin
               if ({1'b0, agent_ff} < (AGENT_W + 1)'(SLOTS)) begin
                  answered_in[agent_ff] = 1'b1;
                  miss_in[aidx]         = cfg.alive_timeout;
               end
            end
            MODE_SHUTDOWN: begin
               if (shut_ff == SHUT_NONE) begin
                  shut_in  = SHUT_REBOOT + ACTION_W'(kind_ff);
                  count_in = cfg.term_timeout;
               end
            end
            MODE_FINISHED: finished_in = 1'b1;
            default: ;
         endcase
      end

      if (cmd.prescale) begin
         kp         = prescale(kdiv_ff, cfg.keepalive_period);
         tp         = prescale(tdiv_ff, cfg.term_check_period);
         ap         = prescale(adiv_ff, cfg.alive_check_period);
         kdiv_in    = kp[CNT_W-1:0];
         tdiv_in    = tp[CNT_W-1:0];
         adiv_in    = ap[CNT_W-1:0];
         kick_in    = kp[CNT_W];
         sent_in    = '0;
         restart_in = '0;
         action_in  = SHUT_NONE;
         if (tp[CNT_W] && shut_ff != SHUT_NONE) begin
            if (count_ff != '0) begin
               cnt = count_ff - 1'b1;
            end
            count_in = cnt;
            if (cnt == '0 || finished_ff) begin
               action_in = shut_ff;
            end
         end
         check_in = ap[CNT_W] && !(shut_ff != SHUT_NONE && cnt < cfg.term_guard_level);
      end

      if (cmd.step && check_ff && cfg.agent_enable_mask[idx]) begin
         if (answered_ff[idx]) begin
            pend = 1'b1;
         end else if (m != '0) begin
            m = m - 1'b1;
         end
         if (m == '0) begin
            restart_in[idx] = 1'b1;
            m               = cfg.alive_timeout;
            pend            = 1'b1;
         end
         if (pend) begin
            if (accept_ff[idx]) begin
               pend         = 1'b0;
               sent_in[idx] = 1'b1;
            end
            answered_in[idx] = 1'b0;
         end
         miss_in[idx]    = m;
         pending_in[idx] = pend;
      end

      if (cmd.publish) begin
         okick_in    = kick_ff;
         osent_in    = sent_ff;
         orestart_in = restart_ff;
         oaction_in  = action_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kdiv_ff     <= '0;
         adiv_ff     <= '0;
         tdiv_ff     <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            miss_ff[i] <= RST_ALIVE_TMO;
         end
         pending_ff  <= SLOT_MASK;
         answered_ff <= '0;
         shut_ff     <= SHUT_NONE;
         count_ff    <= '0;
         finished_ff <= 1'b0;
         check_ff    <= 1'b0;
      end else begin
         kdiv_ff     <= kdiv_in;
         adiv_ff     <= adiv_in;
         tdiv_ff     <= tdiv_in;
         miss_ff     <= miss_in;
         pending_ff  <= pending_in;
         answered_ff <= answered_in;
         shut_ff     <= shut_in;
         count_ff    <= count_in;
         finished_ff <= finished_in;
         check_ff    <= check_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      agent_ff    <= agent_in;
      kind_ff     <= kind_in;
      accept_ff   <= accept_in;
      kick_ff     <= kick_in;
      sent_ff     <= sent_in;
      restart_ff  <= restart_in;
      action_ff   <= action_in;
      okick_ff    <= okick_in;
      osent_ff    <= osent_in;
      orestart_ff <= orestart_in;
      oaction_ff  <= oaction_in;
   end

endmodule

[rtl/multi_agent_heartbeat_supervisor.sv]
// Heartbeat supervisor top level: configuration registers on the APB port,
// controller and datapath. Depends on hbs_pkg, hbs_if, hbs_ctrl, hbs_dp.
//
// Supervises up to eight agents by heartbeat and sequences a reboot or power-off.
// One item is handled at a time. A base tick passes through decode, a scan of
// the miss counters, one agent per cycle over SLOTS agents (SLOTS being AGENTS
// capped at eight), and a finish step that waits for the output register to be
// free before its result is offered; answer, shutdown-start and finished items
// skip the scan. The next item is taken once the previous result is registered,
// even while that result still waits on rsp_chan.
// Registers sit at byte address 4*i; writes should only be made while idle.
module multi_agent_heartbeat_supervisor
   import hbs_pkg::*;
#(
   parameter int AGENTS = AGENTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   hbs_req_if.sink               req_chan,
   hbs_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int SLOTS = (AGENTS < 8) ? AGENTS : 8;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   hbs_cfg_type             cfg_ff;
   hbs_cmd_type             cmd;
   hbs_sts_type             sts;
   logic [IDX_W-1:0]        idx;
   logic [CSR_INDEX_W-1:0]  reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.agent_enable_mask  <= RST_ENABLE_MASK;
         cfg_ff.alive_timeout      <= RST_ALIVE_TMO;
         cfg_ff.term_guard_level   <= RST_TERM_GUARD;
         cfg_ff.term_timeout       <= RST_TERM_TMO;
         cfg_ff.keepalive_period   <= RST_KEEP_PERIOD;
         cfg_ff.alive_check_period <= RST_ALIVE_PERIOD;
         cfg_ff.term_check_period  <= RST_TERM_PERIOD;
      end else if (psel && penable && pwrite) begin
         unique case (reg_index)
            REG_ENABLE_MASK:  cfg_ff.agent_enable_mask  <= pwdata[MASK_W-1:0];
            REG_ALIVE_TMO:    cfg_ff.alive_timeout      <= pwdata[TMO_W-1:0];
            REG_TERM_GUARD:   cfg_ff.term_guard_level   <= pwdata[CNT_W-1:0];
            REG_TERM_TMO:     cfg_ff.term_timeout       <= pwdata[CNT_W-1:0];
            REG_KEEP_PERIOD:  cfg_ff.keepalive_period   <= pwdata[CNT_W-1:0];
            REG_ALIVE_PERIOD: cfg_ff.alive_check_period <= pwdata[CNT_W-1:0];
            REG_TERM_PERIOD:  cfg_ff.term_check_period  <= pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_ENABLE_MASK:  prdata = CSR_DATA_W'(cfg_ff.agent_enable_mask);
         REG_ALIVE_TMO:    prdata = CSR_DATA_W'(cfg_ff.alive_timeout);
         REG_TERM_GUARD:   prdata = CSR_DATA_W'(cfg_ff.term_guard_level);
         REG_TERM_TMO:     prdata = CSR_DATA_W'(cfg_ff.term_timeout);
         REG_KEEP_PERIOD:  prdata = CSR_DATA_W'(cfg_ff.keepalive_period);
         REG_ALIVE_PERIOD: prdata = CSR_DATA_W'(cfg_ff.alive_check_period);
         REG_TERM_PERIOD:  prdata = CSR_DATA_W'(cfg_ff.term_check_period);
         default:          prdata = '0;
      endcase
   end

   hbs_ctrl #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd),
      .idx       (idx)
   );

   hbs_dp #(
      .SLOTS (SLOTS),
      .IDX_W (IDX_W)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd         (cmd),
      .idx         (idx),
      .sts         (sts),
      .in_mode     (req_chan.mode),
      .in_agent    (req_chan.agent),
      .in_kind     (req_chan.shutdown_kind),
      .in_accept   (req_chan.send_accept),
      .out_kick    (rsp_chan.kick),
      .out_sent    (rsp_chan.request_sent),
      .out_restart (rsp_chan.restart),
      .out_action  (rsp_chan.shut_action)
   );

endmodule

[test/tb_multi_agent_heartbeat_supervisor.sv]
// Self-checking testbench for the heartbeat supervisor: drives event items and APB
// register writes, predicts every result item and checks it field by field.
// Depends on hbs_pkg, hbs_if and the multi_agent_heartbeat_supervisor RTL.
`timescale 1ns / 1ps

module tb_multi_agent_heartbeat_supervisor;
   import hbs_pkg::*;

   localparam logic [ACTION_W-1:0] SHUT_POWEROFF = 2'd2;
   localparam int SLOTS       = AGENTS_DEFAULT;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [AGENT_W-1:0] agent;
      logic               kind;
      logic [MASK_W-1:0]  accept;
   } hb_event_type;

   typedef struct packed {
      logic                kick;
      logic [MASK_W-1:0]   sent;
      logic [MASK_W-1:0]   restart;
      logic [ACTION_W-1:0] action;
   } hb_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid  = 1'b0;
   logic [MODE_W-1:0]     req_mode   = '0;
   logic [AGENT_W-1:0]    req_agent  = '0;
   logic                  req_kind   = 1'b0;
   logic [MASK_W-1:0]     req_accept = '0;
   logic                  rsp_ready  = 1'b0;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   hbs_req_if req_chan ();
   hbs_rsp_if rsp_chan ();

   assign req_chan.valid         = req_valid;
   assign req_chan.mode          = req_mode;
   assign req_chan.agent         = req_agent;
   assign req_chan.shutdown_kind = req_kind;
   assign req_chan.send_accept   = req_accept;
   assign rsp_chan.ready         = rsp_ready;

   multi_agent_heartbeat_supervisor u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #2 clock = ~clock;

   // supervisor shadow state
   hbs_cfg_type       cfg;
   logic [CNT_W-1:0]  keep_div, alive_div, term_div;
   logic [TMO_W-1:0]  miss_left [SLOTS];
   logic [MASK_W-1:0] pending, answered;
   logic [ACTION_W-1:0] shut_state;
   logic [CNT_W-1:0]  shut_count;
   logic              all_done;

   hb_event_type   event_q [$];
   hb_verdict_type outcome_q [$];

   hb_event_type   issue, seen_event;
   hb_verdict_type got, want;
   logic        req_took = 1'b0;
   logic        no_gaps = 1'b0;
   int unsigned send_gap = 0, hold_gap = 0, quiet = 0;
   int          errors = 0, items = 0, ticks = 0, results = 0;
   int          kicks = 0, restarts = 0, requests = 0, actions = 0;

   function automatic logic [CNT_W:0] prescale(input logic [CNT_W-1:0] div,
                                               input logic [CNT_W-1:0] period);
      logic [CNT_W-1:0] left;
      left = (div != '0) ? div - 1'b1 : div;
      if (left == '0) return {1'b1, period};
      return {1'b0, left};
   endfunction

   task automatic supervise(input hb_event_type ev, output hb_verdict_type res);
      logic [CNT_W:0] fired;
      res = '0;
      case (ev.mode)
         MODE_ANSWER: begin
            answered[ev.agent] = 1'b1;
            miss_left[ev.agent] = cfg.alive_timeout;
         end
         MODE_SHUTDOWN: begin
            if (shut_state == SHUT_NONE) begin
               shut_state = ev.kind ? SHUT_POWEROFF : SHUT_REBOOT;
               shut_count = cfg.term_timeout;
            end
         end
         MODE_FINISHED: all_done = 1'b1;
         default: begin
            fired = prescale(keep_div, cfg.keepalive_period);
            keep_div = fired[CNT_W-1:0];
            res.kick = fired[CNT_W];
            fired = prescale(term_div, cfg.term_check_period);
            term_div = fired[CNT_W-1:0];
            if (fired[CNT_W] && shut_state != SHUT_NONE) begin
               if (shut_count != '0) shut_count = shut_count - 1'b1;
               if (shut_count == '0 || all_done) res.action = shut_state;
            end
            fired = prescale(alive_div, cfg.alive_check_period);
            alive_div = fired[CNT_W-1:0];
            // alive check held off while shutting down below the guard level
            if (fired[CNT_W] &&
                !(shut_state != SHUT_NONE && shut_count < cfg.term_guard_level)) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (cfg.agent_enable_mask[i]) begin
                     if (answered[i]) pending[i] = 1'b1;
                     else if (miss_left[i] != '0) miss_left[i] = miss_left[i] - 1'b1;
                     if (miss_left[i] == '0) begin
                        res.restart[i] = 1'b1;
                        miss_left[i] = cfg.alive_timeout;
                        pending[i] = 1'b1;
                     end
                     if (pending[i]) begin
                        if (ev.accept[i]) begin
                           pending[i] = 1'b0;
                           res.sent[i] = 1'b1;
                        end
                        answered[i] = 1'b0;
                     end
                  end
               end
            end
         end
      endcase
   endtask

   function automatic int unsigned pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic compare_field(input string name, input logic [MASK_W-1:0] exp_val,
                                input logic [MASK_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $display("t=%0t mismatch on %s: expected %02h, got %02h",
                  $time, name, exp_val, act_val);
         errors++;
      end
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (!no_gaps && send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (event_q.size() != 0) begin
            issue = event_q.pop_front();
            req_mode   <= issue.mode;
            req_agent  <= issue.agent;
            req_kind   <= issue.kind;
            req_accept <= issue.accept;
            req_valid  <= 1'b1;
            send_gap = no_gaps ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (!no_gaps && hold_gap > 0) begin
         hold_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!no_gaps && $urandom_range(0, 3) == 0) hold_gap = pick_gap();
      end
   end

   // monitor, prediction and watchdog
   always @(posedge clock) begin
      req_took <= req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.kick, rsp_chan.request_sent, rsp_chan.restart,
                    rsp_chan.shut_action};
            results++;
            kicks    += got.kick;
            restarts += $countones(got.restart);
            requests += $countones(got.sent);
            actions  += (got.action != SHUT_NONE);
            if (outcome_q.size() == 0) begin
               $display("t=%0t unexpected result item: kick %0b sent %02h",
                        $time, got.kick, got.sent);
               $display("t=%0t    restart %02h action %0d", $time, got.restart, got.action);
               errors++;
            end else begin
               want = outcome_q.pop_front();
               compare_field("kick", MASK_W'(want.kick), MASK_W'(got.kick));
               compare_field("request_sent", want.sent, got.sent);
               compare_field("restart", want.restart, got.restart);
               compare_field("shut_action", MASK_W'(want.action), MASK_W'(got.action));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            seen_event = '{req_chan.mode, req_chan.agent, req_chan.shutdown_kind,
                           req_chan.send_accept};
            supervise(seen_event, want);
            outcome_q.push_back(want);
            items++;
            ticks += (seen_event.mode == MODE_TICK);
         end
         if ((event_q.size() != 0 || req_valid || outcome_q.size() != 0) &&
             !(req_chan.valid && req_chan.ready) && !(rsp_chan.valid && rsp_chan.ready))
            quiet++;
         else
            quiet = 0;
         if (quiet >= QUIET_LIMIT) begin
            $display("t=%0t watchdog: no handshake for %0d cycles", $time, quiet);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_ENABLE_MASK:  cfg.agent_enable_mask  = value[MASK_W-1:0];
         REG_ALIVE_TMO:    cfg.alive_timeout      = value[TMO_W-1:0];
         REG_TERM_GUARD:   cfg.term_guard_level   = value[CNT_W-1:0];
         REG_TERM_TMO:     cfg.term_timeout       = value[CNT_W-1:0];
         REG_KEEP_PERIOD:  cfg.keepalive_period   = value[CNT_W-1:0];
         REG_ALIVE_PERIOD: cfg.alive_check_period = value[CNT_W-1:0];
         REG_TERM_PERIOD:  cfg.term_check_period  = value[CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_event(input logic [MODE_W-1:0] m, input logic [AGENT_W-1:0] a,
                              input logic k, input logic [MASK_W-1:0] acc);
      event_q.push_back('{m, a, k, acc});
   endtask

   task automatic settle();
      while (event_q.size() != 0 || req_valid || outcome_q.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   function automatic logic [CNT_W-1:0] pick_period();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CNT_W'(1);
         2: return CNT_W'(2);
         default: return CNT_W'($urandom_range(3, 12));
      endcase
   endfunction

   task automatic shuffle_settings();
      int r;
      r = $urandom_range(0, 3);
      csr_write(REG_ENABLE_MASK, (r == 0) ? 32'h0 : (r == 1) ? 32'hFF : $urandom_range(0, 255));
      r = $urandom_range(0, 5);
      csr_write(REG_ALIVE_TMO, (r == 0) ? 32'd0 : (r == 1) ? 32'd1 : (r == 2) ? 32'd255
                                        : $urandom_range(2, 8));
      csr_write(REG_TERM_GUARD, $urandom_range(0, 65535));
      csr_write(REG_TERM_TMO, $urandom_range(1, 65535));
      csr_write(REG_KEEP_PERIOD, pick_period());
      csr_write(REG_ALIVE_PERIOD, pick_period());
      csr_write(REG_TERM_PERIOD, pick_period());
   endtask

   // remaining share of the hundred goes to all-finished items
   task automatic run_random(input int count, input int p_tick, input int p_ans,
                             input int p_shut);
      hb_event_type ev;
      int r;
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < p_tick) ev.mode = MODE_TICK;
         else if (r < p_tick + p_ans) ev.mode = MODE_ANSWER;
         else if (r < p_tick + p_ans + p_shut) ev.mode = MODE_SHUTDOWN;
         else ev.mode = MODE_FINISHED;
         ev.agent = AGENT_W'($urandom_range(0, 7));
         ev.kind  = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 7))
            0, 1: ev.accept = '1;
            2: ev.accept = '0;
            default: ev.accept = MASK_W'($urandom);
         endcase
         event_q.push_back(ev);
      end
      settle();
   endtask

   initial begin
      logic [CNT_W-1:0] tto;
      logic             kind;
      cfg = '{RST_ENABLE_MASK, RST_ALIVE_TMO, RST_TERM_GUARD, RST_TERM_TMO,
              RST_KEEP_PERIOD, RST_ALIVE_PERIOD, RST_TERM_PERIOD};
      keep_div = '0;
      alive_div = '0;
      term_div = '0;
      for (int i = 0; i < SLOTS; i++) miss_left[i] = RST_ALIVE_TMO;
      pending = '1;
      answered = '0;
      shut_state = SHUT_NONE;
      shut_count = '0;
      all_done = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: first tick fires every prescaler
      queue_event(MODE_TICK,   3'd0, 1'b0, 8'hFF);
      queue_event(MODE_ANSWER, 3'd0, 1'b0, 8'h00);
      queue_event(MODE_ANSWER, 3'd7, 1'b1, 8'hFF);
      queue_event(MODE_TICK,   3'd0, 1'b0, 8'h00);
      queue_event(MODE_TICK,   3'd5, 1'b1, 8'h81);
      settle();

      // zero periods fire every tick, zero timeout restarts at every check
      csr_write(REG_ENABLE_MASK, 32'hA5);
      csr_write(REG_ALIVE_TMO, 32'd0);
      csr_write(REG_TERM_GUARD, 32'd0);
      csr_write(REG_TERM_TMO, 32'hFFFF);
      csr_write(REG_KEEP_PERIOD, 32'd0);
      csr_write(REG_ALIVE_PERIOD, 32'd0);
      csr_write(REG_TERM_PERIOD, 32'd1);
      queue_event(MODE_TICK,   3'd0, 1'b0, 8'h00);
      queue_event(MODE_TICK,   3'd0, 1'b0, 8'hFF);
      queue_event(MODE_ANSWER, 3'd1, 1'b0, 8'h00);
      queue_event(MODE_ANSWER, 3'd2, 1'b1, 8'h00);
      queue_event(MODE_TICK,   3'd3, 1'b0, 8'h0F);
      queue_event(MODE_TICK,   3'd0, 1'b1, 8'hFF);
      queue_event(MODE_ANSWER, 3'd7, 1'b0, 8'hFF);
      queue_event(MODE_TICK,   3'd6, 1'b0, 8'hF0);
      queue_event(MODE_TICK,   3'd0, 1'b0, 8'h00);
      settle();

      repeat (6) begin
         shuffle_settings();
         run_random(70, 58, 42, 0);
      end

      // shutdown: countdown, guard and repeated action
      tto = ($urandom_range(0, 3) == 0) ? '0 : CNT_W'($urandom_range(5, 15));
      kind = 1'($urandom_range(0, 1));
      csr_write(REG_ENABLE_MASK, 32'hFF);
      csr_write(REG_ALIVE_TMO, 32'd2);
      csr_write(REG_TERM_TMO, {16'h0, tto});
      csr_write(REG_TERM_GUARD, {16'h0, tto >> 1});
      csr_write(REG_TERM_PERIOD, 32'd1);
      csr_write(REG_ALIVE_PERIOD, $urandom_range(0, 2));
      csr_write(REG_KEEP_PERIOD, $urandom_range(1, 4));
      queue_event(MODE_SHUTDOWN, 3'd2, kind, 8'h00);
      queue_event(MODE_SHUTDOWN, 3'd4, ~kind, 8'hFF);
      queue_event(MODE_TICK,     3'd0, 1'b0, 8'hFF);
      queue_event(MODE_TICK,     3'd0, 1'b0, 8'h00);
      run_random(40, 60, 35, 5);

      csr_write(REG_TERM_GUARD, 32'hFFFF);
      run_random(30, 60, 37, 3);

      csr_write(REG_TERM_GUARD, 32'd0);
      queue_event(MODE_FINISHED, 3'd0, 1'b0, 8'h00);
      run_random(40, 60, 33, 3);

      // largest register values
      csr_write(REG_ALIVE_TMO, 32'd255);
      csr_write(REG_TERM_TMO, 32'hFFFF);
      csr_write(REG_KEEP_PERIOD, 32'hFFFF);
      csr_write(REG_ALIVE_PERIOD, 32'hFFFF);
      csr_write(REG_TERM_PERIOD, 32'hFFFF);
      run_random(15, 80, 20, 0);

      $display("Summary: %0d items in (%0d base ticks), %0d results checked", items, ticks,
               results);
      $display("Summary: %0d keepalive pulses, %0d requests, %0d restarts, %0d shutdown actions",
               kicks, requests, restarts, actions);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[sim.f]
rtl/hbs_pkg.sv
rtl/hbs_if.sv
rtl/hbs_ctrl.sv
rtl/hbs_dp.sv
rtl/multi_agent_heartbeat_supervisor.sv
test/tb_multi_agent_heartbeat_supervisor.sv
